/* rtl/core/telemetry_frame_builder_crc16_top_assert.svh */
//------------------------------------------------------------------------------
// Assertion macros for the telemetry frame builder
// Shared forms for the concurrent checks on the top level ports.
//------------------------------------------------------------------------------
`ifndef TELEMETRY_FRAME_BUILDER_CRC16_TOP_ASSERT_SVH
`define TELEMETRY_FRAME_BUILDER_CRC16_TOP_ASSERT_SVH

// Check that is switched off while reset is asserted.
`define TFB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also runs during reset.
`define TFB_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/tfb_pkg.sv */
//------------------------------------------------------------------------------
// tfb_pkg
// Types, constants and the CRC-16/MODBUS byte update for the frame builder.
//------------------------------------------------------------------------------
package tfb_pkg;

    localparam int unsigned APB_AW = 5;
    localparam int unsigned APB_DW = 64;

    // Register indexes (byte address is 8 times the index).
    localparam logic [1:0] REG_SCHEMA  = 2'd0;
    localparam logic [1:0] REG_MODEL   = 2'd1;
    localparam logic [1:0] REG_DEVICE  = 2'd2;
    localparam logic [1:0] REG_TOKEN   = 2'd3;

    localparam int unsigned HDR_LEN = 13;

    // Output phases of one held item.
    localparam logic [3:0] PH_HDR_FIRST = 4'd0;
    localparam logic [3:0] PH_HDR_LAST  = 4'd12;
    localparam logic [3:0] PH_DATA      = 4'd13;
    localparam logic [3:0] PH_CRC_LO    = 4'd14;
    localparam logic [3:0] PH_CRC_HI    = 4'd15;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic [7:0]  schema_version;
        logic [7:0]  model_version;
        logic [15:0] device_id;
        logic [63:0] access_token;
    } t_cfg;

    typedef struct packed {
        logic       valid;
        logic [7:0] out_byte;
        logic       end_of_frame;
    } t_emit;

    function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* rtl/core/telemetry_frame_builder_crc16_top.sv */
//------------------------------------------------------------------------------
// telemetry_frame_builder_crc16_top
// Frames a payload byte stream with a header and a CRC-16/MODBUS trailer.
//------------------------------------------------------------------------------
// Input channel (i_valid / o_stall) carries payload bytes with a last flag;
// output channel (o_valid / i_stall) carries the framed byte stream, with
// o_end_of_frame set on the high CRC byte. The header fields are set over the
// APB port, which is to be written by the user only while the block is idle;
// the block itself does not enforce this. A byte that opens a frame is sent
// after 13 header bytes, and a last byte is followed by the two CRC
// trailer bytes. The sequencer emits one byte per cycle into the output
// register while the receiver does not stall, so payload bytes in an open
// frame flow at one per cycle. The first output byte passes through the
// holding register and the output register before it is presented.
// Reset drops any open frame without a trailer, empties both registers and
// clears the header fields. When the receiver stalls, the output register
// holds its byte and the sequencer waits; the input side stalls once the
// holding register is busy.
//------------------------------------------------------------------------------
module telemetry_frame_builder_crc16_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [7:0]                   i_data_byte,
    input  logic                         i_last_byte,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [7:0]                   o_out_byte,
    output logic                         o_end_of_frame,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tfb_pkg::APB_AW-1:0]   paddr,
    input  logic [tfb_pkg::APB_DW-1:0]   pwdata,
    output logic [tfb_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    tfb_pkg::t_cfg  w_cfg;
    tfb_pkg::t_emit w_emit;
    logic           w_out_ready;

    logic           r_out_valid;
    logic [7:0]     r_out_byte;
    logic           r_out_eof;

    tfb_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tfb_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_cfg       (w_cfg),
        .i_out_ready (w_out_ready),
        .o_emit      (w_emit)
    );

    assign w_out_ready = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit.valid) begin
            r_out_byte <= w_emit.out_byte;
            r_out_eof  <= w_emit.end_of_frame;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_end_of_frame = r_out_eof;

endmodule

/* rtl/core/tfb_cfg.sv */
//------------------------------------------------------------------------------
// tfb_cfg
// APB register file holding the header fields of the frame.
//------------------------------------------------------------------------------
module tfb_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tfb_pkg::APB_AW-1:0]   paddr,
    input  logic [tfb_pkg::APB_DW-1:0]   pwdata,
    output logic [tfb_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output tfb_pkg::t_cfg                o_cfg
);

    tfb_pkg::t_cfg r_cfg;
    logic [1:0]    w_idx;

    assign w_idx  = paddr[tfb_pkg::APB_AW-1:3];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (w_idx)
                tfb_pkg::REG_SCHEMA: r_cfg.schema_version <= pwdata[7:0];
                tfb_pkg::REG_MODEL:  r_cfg.model_version  <= pwdata[7:0];
                tfb_pkg::REG_DEVICE: r_cfg.device_id      <= pwdata[15:0];
                tfb_pkg::REG_TOKEN:  r_cfg.access_token   <= pwdata[63:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            tfb_pkg::REG_SCHEMA: prdata = {56'd0, r_cfg.schema_version};
            tfb_pkg::REG_MODEL:  prdata = {56'd0, r_cfg.model_version};
            tfb_pkg::REG_DEVICE: prdata = {48'd0, r_cfg.device_id};
            tfb_pkg::REG_TOKEN:  prdata = r_cfg.access_token;
            default:             prdata = '0;
        endcase
    end

endmodule

/* rtl/core/tfb_seq.sv */
//------------------------------------------------------------------------------
// tfb_seq
// Input holding register, byte sequencer and running CRC of the frame.
//------------------------------------------------------------------------------
module tfb_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [7:0]     i_data_byte,
    input  logic           i_last_byte,
    input  tfb_pkg::t_cfg  i_cfg,
    input  logic           i_out_ready,
    output tfb_pkg::t_emit o_emit
);

    logic        r_in_valid;
    logic [7:0]  r_in_data;
    logic        r_in_last;
    logic [3:0]  r_phase;
    logic        r_in_frame;
    logic [15:0] r_crc;

    logic        n_in_valid;
    logic [3:0]  n_phase;
    logic        n_in_frame;
    logic [15:0] n_crc;

    logic        w_step;
    logic        w_done;
    logic        w_load;
    logic [7:0]  w_byte;
    logic [7:0]  w_hdr [tfb_pkg::HDR_LEN];

    assign w_hdr[0]  = i_cfg.schema_version;
    assign w_hdr[1]  = i_cfg.model_version;
    assign w_hdr[2]  = i_cfg.device_id[15:8];
    assign w_hdr[3]  = i_cfg.device_id[7:0];
    assign w_hdr[4]  = i_cfg.access_token[63:56];
    assign w_hdr[5]  = i_cfg.access_token[55:48];
    assign w_hdr[6]  = i_cfg.access_token[47:40];
    assign w_hdr[7]  = i_cfg.access_token[39:32];
    assign w_hdr[8]  = i_cfg.access_token[31:24];
    assign w_hdr[9]  = i_cfg.access_token[23:16];
    assign w_hdr[10] = i_cfg.access_token[15:8];
    assign w_hdr[11] = i_cfg.access_token[7:0];
    assign w_hdr[12] = 8'h00;

    always_comb begin
        case (r_phase)
            tfb_pkg::PH_DATA:   w_byte = r_in_data;
            tfb_pkg::PH_CRC_LO: w_byte = r_crc[7:0];
            tfb_pkg::PH_CRC_HI: w_byte = r_crc[15:8];
            default:            w_byte = w_hdr[r_phase];
        endcase
    end

    always_comb begin
        w_step  = r_in_valid && i_out_ready;
        w_done  = ((r_phase == tfb_pkg::PH_DATA) && !r_in_last) ||
                  (r_phase == tfb_pkg::PH_CRC_HI);
        o_stall = r_in_valid && !(w_step && w_done);
        w_load  = i_valid && !o_stall;

        n_in_frame = r_in_frame;
        if (w_step && (r_phase == tfb_pkg::PH_HDR_LAST)) begin
            n_in_frame = 1'b1;
        end
        if (w_step && (r_phase == tfb_pkg::PH_CRC_HI)) begin
            n_in_frame = 1'b0;
        end

        n_phase = r_phase;
        if (w_step) begin
            n_phase = r_phase + 4'd1;
        end
        // The next item skips the header when its frame is already open.
        if (w_load) begin
            n_phase = n_in_frame ? tfb_pkg::PH_DATA : tfb_pkg::PH_HDR_FIRST;
        end

        n_in_valid = r_in_valid;
        if (w_step && w_done) begin
            n_in_valid = 1'b0;
        end
        if (w_load) begin
            n_in_valid = 1'b1;
        end

        // The CRC restarts on the first header byte and covers header and payload.
        n_crc = r_crc;
        if (w_step && (r_phase <= tfb_pkg::PH_DATA)) begin
            n_crc = tfb_pkg::crc16_feed(
                (r_phase == tfb_pkg::PH_HDR_FIRST) ? tfb_pkg::CRC_INIT : r_crc, w_byte);
        end

        o_emit.valid        = w_step;
        o_emit.out_byte     = w_byte;
        o_emit.end_of_frame = (r_phase == tfb_pkg::PH_CRC_HI);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= tfb_pkg::PH_HDR_FIRST;
            r_in_frame <= 1'b0;
            r_crc      <= tfb_pkg::CRC_INIT;
        end else begin
            r_in_valid <= n_in_valid;
            r_phase    <= n_phase;
            r_in_frame <= n_in_frame;
            r_crc      <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_in_data <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

endmodule

/* rtl/core/tfb_chk.sv */
//------------------------------------------------------------------------------
// tfb_chk
// Port-level checks on the frame builder, bound to the top level.
//------------------------------------------------------------------------------
`include "telemetry_frame_builder_crc16_top_assert.svh"

module tfb_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_byte,
    input logic       o_end_of_frame,
    input logic       pready
);

    // A stalled output transaction keeps its byte.
    `TFB_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_out_byte), "output byte changed while stalled")

    // The byte after a frame end opens a new header, so it never ends a frame.
    `TFB_ASSERT(a_eof_single, i_clk, i_rst_n, o_valid && !i_stall && o_end_of_frame |=> !(o_valid && o_end_of_frame), "two frame ends in a row")

    // Reset leaves both channels empty.
    `TFB_ASSERT_RST(a_rst_out, i_clk, !i_rst_n |=> !o_valid, "output valid after reset")
    `TFB_ASSERT_RST(a_rst_in, i_clk, !i_rst_n |=> !o_stall, "input stalled after reset")

    // The register port never inserts wait states.
    `TFB_ASSERT(a_pready, i_clk, i_rst_n, pready, "pready low")

endmodule

bind telemetry_frame_builder_crc16_top tfb_chk u_tfb_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_out_byte     (o_out_byte),
    .o_end_of_frame (o_end_of_frame),
    .pready         (pready)
);

/* test/testbench.sv */
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// Telemetry frame builder testbench
// Sends payload bytes as framed transactions with random gaps and receiver
// stalls. It also rewrites the header fields over the APB port between
// phases. Every output byte is checked against a frame predictor that builds
// the header, the payload echo and the CRC-16/MODBUS trailer.
//------------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_payload;

    typedef struct packed {
        logic [7:0] value;
        logic       eof;
    } t_framed_byte;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_valid = 1'b0;
    logic                        o_stall;
    logic [7:0]                  i_data_byte = 8'h00;
    logic                        i_last_byte = 1'b0;
    logic                        o_valid;
    logic                        i_stall = 1'b0;
    logic [7:0]                  o_out_byte;
    logic                        o_end_of_frame;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [tfb_pkg::APB_AW-1:0]  paddr = '0;
    logic [tfb_pkg::APB_DW-1:0]  pwdata = '0;
    logic [tfb_pkg::APB_DW-1:0]  prdata;
    logic                        pready;

    // Predictor state: header fields as last written, frame status, running CRC.
    tfb_pkg::t_cfg               hdr_cfg = '0;
    logic                        frame_open = 1'b0;
    logic [15:0]                 frame_crc = tfb_pkg::CRC_INIT;

    t_payload                    pending_bytes[$];
    t_framed_byte                frame_bytes_due[$];
    int                          n_issued = 0;
    int                          n_taken = 0;
    int                          n_failures = 0;
    int                          cycle_count = 0;
    bit                          calm = 1'b0;
    bit                          drv_busy;
    int                          send_gap = 0;
    int                          stall_left = 0;
    t_payload                    next_item;
    t_framed_byte                due;

    telemetry_frame_builder_crc16_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_end_of_frame (o_end_of_frame),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly short idle stretches, a few long ones, none while calm is set.
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 20);
    endfunction

    function automatic logic [15:0] modbus_crc_step(input logic [15:0] acc,
                                                    input logic [7:0] b);
        logic [15:0] r;
        r = acc ^ {8'h00, b};
        repeat (8) r = r[0] ? ((r >> 1) ^ tfb_pkg::CRC_POLY) : (r >> 1);
        return r;
    endfunction

    task automatic push_framed(input logic [7:0] value, input logic eof, input bit fold);
        t_framed_byte fb;
        fb.value = value;
        fb.eof = eof;
        frame_bytes_due.push_back(fb);
        if (fold) begin
            frame_crc = modbus_crc_step(frame_crc, value);
        end
    endtask

    // Expected output for one accepted payload transaction.
    task automatic predict_framed_bytes(input logic [7:0] data, input logic last);
        logic [15:0] crc;
        if (!frame_open) begin
            frame_crc = tfb_pkg::CRC_INIT;
            push_framed(hdr_cfg.schema_version, 1'b0, 1'b1);
            push_framed(hdr_cfg.model_version, 1'b0, 1'b1);
            push_framed(hdr_cfg.device_id[15:8], 1'b0, 1'b1);
            push_framed(hdr_cfg.device_id[7:0], 1'b0, 1'b1);
            for (int sh = 56; sh >= 0; sh -= 8) begin
                push_framed(hdr_cfg.access_token[sh +: 8], 1'b0, 1'b1);
            end
            push_framed(8'h00, 1'b0, 1'b1);
            frame_open = 1'b1;
        end
        push_framed(data, 1'b0, 1'b1);
        if (last) begin
            crc = frame_crc;
            push_framed(crc[7:0], 1'b0, 1'b0);
            push_framed(crc[15:8], 1'b1, 1'b0);
            frame_open = 1'b0;
            frame_crc = tfb_pkg::CRC_INIT;
        end
    endtask

    // Driver: one payload transaction at a time, random gaps in between.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            drv_busy = i_valid;
            if (i_valid && !o_stall) begin
                predict_framed_bytes(i_data_byte, i_last_byte);
                n_taken++;
                drv_busy = 1'b0;
            end
            if (!drv_busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_bytes.size() > 0) begin
                    next_item = pending_bytes.pop_front();
                    i_data_byte <= next_item.data;
                    i_last_byte <= next_item.last;
                    drv_busy = 1'b1;
                    send_gap = pick_idle_len();
                end
            end
            i_valid <= drv_busy;
        end
    end

    // Monitor: checks each output transaction and drives the receiver stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (frame_bytes_due.size() == 0) begin
                    $display("%0t: unexpected byte %02h eof %0b", $time, o_out_byte,
                             o_end_of_frame);
                    n_failures++;
                end else begin
                    due = frame_bytes_due.pop_front();
                    if (o_out_byte !== due.value) begin
                        $display("%0t: out_byte expected %02h actual %02h", $time,
                                 due.value, o_out_byte);
                        n_failures++;
                    end
                    if (o_end_of_frame !== due.eof) begin
                        $display("%0t: end_of_frame expected %0b actual %0b", $time,
                                 due.eof, o_end_of_frame);
                        n_failures++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                stall_left = pick_idle_len();
                if (stall_left > 0) begin
                    stall_left--;
                    i_stall <= 1'b1;
                end else begin
                    i_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d bytes still expected", $time,
                     frame_bytes_due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic queue_byte(input logic [7:0] data, input logic last);
        t_payload item;
        item.data = data;
        item.last = last;
        pending_bytes.push_back(item);
        n_issued++;
    endtask

    task automatic queue_random_frame();
        int r;
        int len;
        r = $urandom_range(0, 9);
        if (r < 3) begin
            len = 1;
        end else if (r < 8) begin
            len = $urandom_range(2, 6);
        end else begin
            len = $urandom_range(7, 24);
        end
        for (int k = 0; k < len; k++) begin
            queue_byte(8'($urandom_range(0, 255)), k == len - 1);
        end
    endtask

    // Waits until every transaction is taken and every expected byte seen.
    task automatic settle();
        while (n_taken != n_issued || frame_bytes_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            tfb_pkg::REG_SCHEMA: hdr_cfg.schema_version = val[7:0];
            tfb_pkg::REG_MODEL:  hdr_cfg.model_version = val[7:0];
            tfb_pkg::REG_DEVICE: hdr_cfg.device_id = val[15:0];
            tfb_pkg::REG_TOKEN:  hdr_cfg.access_token = val;
            default: ;
        endcase
    endtask

    task automatic write_all_config(input logic [7:0] schema, input logic [7:0] model,
                                    input logic [15:0] dev, input logic [63:0] token);
        apb_write(tfb_pkg::REG_SCHEMA, {$urandom, 24'($urandom_range(0, 16777215)), schema});
        apb_write(tfb_pkg::REG_MODEL, {$urandom, 24'($urandom_range(0, 16777215)), model});
        apb_write(tfb_pkg::REG_DEVICE, {$urandom, 16'($urandom_range(0, 65535)), dev});
        apb_write(tfb_pkg::REG_TOKEN, token);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Header fields still at their reset value, no idling on either side.
        calm = 1'b1;
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b1);
        settle();
        calm = 1'b0;

        write_all_config(8'hFF, 8'hFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hA5, 1'b1);
        queue_byte(8'h00, 1'b1);
        queue_byte(8'h7E, 1'b0);
        settle();

        // The open frame already carries its header; the new fields only
        // show up once the next frame opens.
        write_all_config(8'h80, 8'h01, 16'h8001, 64'h8000_0000_0000_0001);
        queue_byte(8'h81, 1'b1);
        queue_byte(8'h55, 1'b0);
        queue_byte(8'hAA, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h80, 1'b1);
        settle();

        for (int phase = 0; phase < 6; phase++) begin
            calm = (phase == 2);
            if (phase == 4) begin
                write_all_config(8'h00, 8'h00, 16'h0000, 64'h0);
            end else begin
                if ($urandom_range(0, 1)) begin
                    apb_write(tfb_pkg::REG_SCHEMA, {$urandom, $urandom});
                end
                if ($urandom_range(0, 1)) begin
                    apb_write(tfb_pkg::REG_MODEL, {$urandom, $urandom});
                end
                apb_write(tfb_pkg::REG_DEVICE, {$urandom, $urandom});
                apb_write(tfb_pkg::REG_TOKEN, {$urandom, $urandom});
            end
            while (n_issued < 15 + 25 * (phase + 1)) begin
                queue_random_frame();
            end
            settle();
        end

        repeat (20) @(posedge i_clk);
        if (n_failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/tfb_pkg.sv
rtl/core/tfb_cfg.sv
rtl/core/tfb_seq.sv
rtl/core/telemetry_frame_builder_crc16_top.sv
rtl/core/tfb_chk.sv
test/testbench.sv
